[design/lpe_pkg.sv]
// Shared types and constants for the LED pixel PWM encoder.
// No dependencies; imported by every module of the block.
package lpe_pkg;

   localparam int PIXELS         = 256;
   localparam int BITS_PER_PIXEL = 24;
   localparam int FULL_SCALE     = 256;

   localparam int INDEX_W   = 12;
   localparam int CHAN_W    = 8;
   localparam int LEVEL_W   = 9;
   localparam int COUNT_W   = 16;
   localparam int HEAD_W    = 8;
   localparam int SLOT_W    = 13;
   localparam int WORD_W    = 3 * CHAN_W;
   localparam int BIT_CNT_W = $clog2(BITS_PER_PIXEL);

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_BRIGHTNESS = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_ONE_HIGH   = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_ZERO_HIGH  = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_HEAD       = CSR_IDX_W'(3);

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   typedef struct packed {
      logic [INDEX_W-1:0] pixel_index;
      logic [CHAN_W-1:0]  red;
      logic [CHAN_W-1:0]  green;
      logic [CHAN_W-1:0]  blue;
   } lpe_req_type;

   typedef struct packed {
      logic [COUNT_W-1:0] compare_value;
      logic [SLOT_W-1:0]  buffer_slot;
      logic               last_bit;
   } lpe_rsp_type;

   // one classified pixel, ready for bit streaming
   typedef struct packed {
      logic [WORD_W-1:0] grb;
      logic [SLOT_W-1:0] base;
   } lpe_job_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] brightness_level;
      logic [COUNT_W-1:0] one_high_count;
      logic [COUNT_W-1:0] zero_high_count;
      logic [HEAD_W-1:0]  head_offset;
   } lpe_csr_type;

endpackage

[design/lpe_front.sv]
// Front end: clamps the pixel index, scales the channels and builds the job.
// Depends on lpe_pkg.
module lpe_front
   import lpe_pkg::*;
(
   input  logic        accept,
   input  lpe_req_type req,
   input  lpe_csr_type csr,
   output logic        push,
   output lpe_job_type job
);

   logic [LEVEL_W-1:0]  factor;
   logic [INDEX_W-1:0]  index_clamped;
   logic [LEVEL_W+CHAN_W-1:0] prod_r, prod_g, prod_b;
   logic [SLOT_W-1:0]   pixel_offset;

   always_comb begin
      factor = (csr.brightness_level > LEVEL_W'(FULL_SCALE)) ?
               LEVEL_W'(FULL_SCALE) : csr.brightness_level;
      index_clamped = (req.pixel_index > INDEX_W'(PIXELS - 1)) ?
                      INDEX_W'(PIXELS - 1) : req.pixel_index;
      prod_r = (LEVEL_W+CHAN_W)'(req.red)   * (LEVEL_W+CHAN_W)'(factor);
      prod_g = (LEVEL_W+CHAN_W)'(req.green) * (LEVEL_W+CHAN_W)'(factor);
      prod_b = (LEVEL_W+CHAN_W)'(req.blue)  * (LEVEL_W+CHAN_W)'(factor);
      pixel_offset = SLOT_W'(index_clamped) * SLOT_W'(BITS_PER_PIXEL);
      // green first on the wire
      job.grb  = {prod_g[2*CHAN_W-1:CHAN_W], prod_r[2*CHAN_W-1:CHAN_W],
                  prod_b[2*CHAN_W-1:CHAN_W]};
      job.base = SLOT_W'(csr.head_offset) + pixel_offset;
      push     = accept;
   end

endmodule

[design/lpe_queue.sv]
// Short job queue between front end and bit streamer.
// Depends on lpe_pkg.
module lpe_queue
   import lpe_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  lpe_job_type push_job,
   input  logic        pop,
   output lpe_job_type head_job,
   output logic        empty,
   output logic        full
);

   lpe_job_type               entry_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]         count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QUEUE_AW'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QUEUE_AW'(1) : rd_ptr_ff;
      count_in  = count_ff + (QUEUE_AW+1)'(push) - (QUEUE_AW+1)'(pop);
      empty     = (count_ff == '0);
      full      = (count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
      head_job  = entry_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

[design/lpe_back.sv]
// Back end: streams 24 compare values per job, one per cycle, MSB first.
// Depends on lpe_pkg.
module lpe_back
   import lpe_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        job_empty,
   input  lpe_job_type job,
   input  lpe_csr_type csr,
   output logic        pop,
   output logic        rsp_valid,
   output lpe_rsp_type rsp_data
);

   logic                 active_ff, active_in;
   logic [WORD_W-1:0]    word_ff, word_in;
   logic [SLOT_W-1:0]    slot_ff, slot_in;
   logic [BIT_CNT_W-1:0] bit_cnt_ff, bit_cnt_in;
   logic                 last;

   always_comb begin
      last       = (bit_cnt_ff == BIT_CNT_W'(BITS_PER_PIXEL - 1));
      pop        = !job_empty && (!active_ff || last);
      active_in  = active_ff;
      word_in    = {word_ff[WORD_W-2:0], 1'b0};
      slot_in    = slot_ff + SLOT_W'(1);
      bit_cnt_in = bit_cnt_ff + BIT_CNT_W'(1);
      if (pop) begin
         active_in  = 1'b1;
         word_in    = job.grb;
         slot_in    = job.base;
         bit_cnt_in = '0;
      end else if (last) begin
         active_in  = 1'b0;
      end
   end

   always_comb begin
      rsp_valid              = active_ff;
      rsp_data.compare_value = word_ff[WORD_W-1] ? csr.one_high_count
                                                 : csr.zero_high_count;
      rsp_data.buffer_slot   = slot_ff;
      rsp_data.last_bit      = last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff  <= 1'b0;
         bit_cnt_ff <= '0;
      end else begin
         active_ff  <= active_in;
         bit_cnt_ff <= bit_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
      slot_ff <= slot_in;
   end

endmodule

[design/led_pixel_pwm_encoder.sv]
// LED pixel PWM encoder: pixel in, 24 timer compare values out (GRB, MSB first).
// Path: an accepted pixel is written into the job queue, then loaded into the streamer
// registers that drive rsp_; the streamer emits one bit a cycle, and a two-entry job
// queue lets two more pixels be taken while one streams.
// Reset: synchronous, active high; clears queue and streamer, loads register
// defaults (brightness full, counts and head offset zero). Receiver cannot stall.
module led_pixel_pwm_encoder
   import lpe_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // pixel transaction
   input  logic                  start,
   output logic                  busy,
   input  lpe_req_type           req_data,
   // bit transactions, one per cycle, no backpressure
   output logic                  rsp_valid,
   output lpe_rsp_type           rsp_data,
   // register writes
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   lpe_csr_type csr_ff, csr_in;
   logic        accept;
   logic        push;
   lpe_job_type push_job;
   lpe_job_type head_job;
   logic        pop;
   logic        q_empty;
   logic        q_full;

   // Registers are always writable; writes to unknown indexes are dropped.
   assign csr_ready = 1'b1;

   always_comb begin
      csr_in = csr_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_BRIGHTNESS: csr_in.brightness_level = csr_data[LEVEL_W-1:0];
            CSR_ONE_HIGH:   csr_in.one_high_count   = csr_data[COUNT_W-1:0];
            CSR_ZERO_HIGH:  csr_in.zero_high_count  = csr_data[COUNT_W-1:0];
            CSR_HEAD:       csr_in.head_offset      = csr_data[HEAD_W-1:0];
            default:        csr_in = csr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.brightness_level <= LEVEL_W'(FULL_SCALE);
         csr_ff.one_high_count   <= '0;
         csr_ff.zero_high_count  <= '0;
         csr_ff.head_offset      <= '0;
      end else begin
         csr_ff <= csr_in;
      end
   end

   // busy only while the job queue is full
   assign busy   = q_full;
   assign accept = start && !q_full;

   lpe_front u_front (
      .accept (accept),
      .req    (req_data),
      .csr    (csr_ff),
      .push   (push),
      .job    (push_job)
   );

   lpe_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .empty    (q_empty),
      .full     (q_full)
   );

   lpe_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_empty (q_empty),
      .job       (head_job),
      .csr       (csr_ff),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

[tb/led_pixel_pwm_encoder_test.sv]
// Self-checking testbench for the LED pixel PWM encoder (led_pixel_pwm_encoder).
// Depends on lpe_pkg for the port types, register indexes and block constants.
// Directed tests cover the corners, then random traffic runs under changing settings.
module led_pixel_pwm_encoder_test;
   import lpe_pkg::*;

   localparam int PERIOD       = 12;
   localparam int CYCLE_LIMIT  = 200000;  // far beyond the slowest correct run
   localparam int RANDOM_ITEMS = 410;
   localparam int DRAIN_CYCLES = 6;

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   lpe_req_type           req_data;
   logic                  rsp_valid;
   lpe_rsp_type           rsp_data;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   // Shadow copy of the register file, updated on every accepted write.
   lpe_csr_type           model_csr;
   // Bit transactions still owed by the block, oldest first.
   lpe_rsp_type           pending_bits[$];

   int errors;
   int pixels_sent;
   int bits_checked;
   int csr_writes;
   int cycles;
   bit no_gaps;   // when set, the sender offers pixels back to back

   led_pixel_pwm_encoder i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #(PERIOD / 2) clock = ~clock;
   end

   // Watchdog: a hung handshake or a lost bit ends the run here.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // Prediction
   // ---------------------------------------------------------------------------

   // Q1.8 scaling; anything above full brightness acts as full.
   function automatic logic [CHAN_W-1:0] dim_channel(input logic [CHAN_W-1:0] c);
      logic [LEVEL_W-1:0] f;
      logic [16:0]        p;
      f = (model_csr.brightness_level > FULL_SCALE) ? LEVEL_W'(FULL_SCALE)
                                                    : model_csr.brightness_level;
      p = c * f;
      return p[15:8];
   endfunction

   // Queue the 24 bit transactions one pixel must produce: GRB order, MSB first.
   function automatic void encode_pixel(input lpe_req_type px);
      logic [INDEX_W-1:0] idx;
      logic [WORD_W-1:0]  grb;
      logic [SLOT_W-1:0]  base;
      lpe_rsp_type        r;
      // pixels past the end of the strip land on the last one
      idx  = (px.pixel_index > PIXELS - 1) ? INDEX_W'(PIXELS - 1) : px.pixel_index;
      grb  = {dim_channel(px.green), dim_channel(px.red), dim_channel(px.blue)};
      base = SLOT_W'(int'(model_csr.head_offset) + BITS_PER_PIXEL * int'(idx));
      for (int j = 0; j < BITS_PER_PIXEL; j++) begin
         r.compare_value = grb[WORD_W-1-j] ? model_csr.one_high_count
                                           : model_csr.zero_high_count;
         r.buffer_slot   = base + SLOT_W'(j);
         r.last_bit      = (j == BITS_PER_PIXEL - 1);
         pending_bits.push_back(r);
      end
   endfunction

   function automatic void update_csr_model(input logic [CSR_IDX_W-1:0]  idx,
                                            input logic [CSR_DATA_W-1:0] data);
      case (idx)
         CSR_BRIGHTNESS: model_csr.brightness_level = data[LEVEL_W-1:0];
         CSR_ONE_HIGH:   model_csr.one_high_count   = data[COUNT_W-1:0];
         CSR_ZERO_HIGH:  model_csr.zero_high_count  = data[COUNT_W-1:0];
         CSR_HEAD:       model_csr.head_offset      = data[HEAD_W-1:0];
         default: ;     // unmapped index, write is dropped
      endcase
   endfunction

   // ---------------------------------------------------------------------------
   // Checking: every strobed bit transaction against the oldest prediction
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin : bit_checker
      lpe_rsp_type want;
      if (!reset && rsp_valid) begin
         if (pending_bits.size() == 0) begin
            $error("bit transaction with none pending: slot %0d value %0h",
                   rsp_data.buffer_slot, rsp_data.compare_value);
            errors++;
         end else begin
            want = pending_bits.pop_front();
            bits_checked++;
            if (rsp_data.compare_value !== want.compare_value) begin
               $error("compare_value: expected %0h, got %0h",
                      want.compare_value, rsp_data.compare_value);
               errors++;
            end
            if (rsp_data.buffer_slot !== want.buffer_slot) begin
               $error("buffer_slot: expected %0d, got %0d",
                      want.buffer_slot, rsp_data.buffer_slot);
               errors++;
            end
            if (rsp_data.last_bit !== want.last_bit) begin
               $error("last_bit: expected %0b, got %0b",
                      want.last_bit, rsp_data.last_bit);
               errors++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Drivers
   // ---------------------------------------------------------------------------

   // Offer one pixel after a random gap. start stays high on return so a
   // following pixel with no gap goes out on the very next edge.
   task automatic send_pixel(input lpe_req_type px);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 9);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= px;
      do @(posedge clock); while (busy);
      encode_pixel(px);
      pixels_sent++;
   endtask

   // Drop start and let the block drain completely.
   task automatic wait_idle();
      start <= 1'b0;
      while (pending_bits.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // csr_valid is left high so consecutive writes need no extra edge;
   // csr_release drops it after the last one of a group.
   task automatic write_csr(input logic [CSR_IDX_W-1:0]  idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      update_csr_model(idx, data);
      csr_writes++;
   endtask

   task automatic csr_release();
      csr_valid <= 1'b0;
   endtask

   task automatic apply_setting(input logic [CSR_DATA_W-1:0] level,
                                input logic [CSR_DATA_W-1:0] one_cnt,
                                input logic [CSR_DATA_W-1:0] zero_cnt,
                                input logic [CSR_DATA_W-1:0] head);
      write_csr(CSR_BRIGHTNESS, level);
      write_csr(CSR_ONE_HIGH, one_cnt);
      write_csr(CSR_ZERO_HIGH, zero_cnt);
      write_csr(CSR_HEAD, head);
      csr_release();
   endtask

   function automatic lpe_req_type make_pixel(input int idx, input int r,
                                              input int g, input int b);
      lpe_req_type px;
      px.pixel_index = INDEX_W'(idx);
      px.red         = CHAN_W'(r);
      px.green       = CHAN_W'(g);
      px.blue        = CHAN_W'(b);
      return px;
   endfunction

   // Mostly on-strip indexes, with a share past the end and at the corners.
   function automatic lpe_req_type random_pixel();
      int idx;
      case ($urandom_range(0, 9))
         0:       idx = PIXELS - 1;
         1:       idx = $urandom_range(PIXELS, (1 << INDEX_W) - 1);
         2:       idx = 0;
         default: idx = $urandom_range(0, PIXELS - 1);
      endcase
      return make_pixel(idx, $urandom_range(0, 255), $urandom_range(0, 255),
                        $urandom_range(0, 255));
   endfunction

   // ---------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------

   // Reset values: full brightness, both counts zero, no head offset.
   task automatic test_reset_defaults();
      send_pixel(make_pixel(0, 255, 255, 255));
      send_pixel(make_pixel(17, 18, 52, 86));
      wait_idle();
   endtask

   // Field corners, channel order and index clamping at full brightness.
   task automatic test_field_extremes();
      apply_setting(CSR_DATA_W'(FULL_SCALE), 16'hFFFF, 16'h0000, 16'h0000);
      send_pixel(make_pixel(0, 0, 0, 0));
      send_pixel(make_pixel(0, 255, 255, 255));
      send_pixel(make_pixel(PIXELS - 1, 8'h0F, 8'hF0, 8'h3C));   // GRB order
      send_pixel(make_pixel(PIXELS, 8'hAA, 8'h55, 8'h80));       // just past the end
      send_pixel(make_pixel((1 << INDEX_W) - 1, 8'h01, 8'h80, 8'hFE));
      send_pixel(make_pixel(12'hAAA, 8'h55, 8'hAA, 8'h7F));
      send_pixel(make_pixel(12'h555, 8'h80, 8'h01, 8'hFF));
      wait_idle();
   endtask

   // Scaling from off through full, values above full, and data bits that
   // the register does not keep.
   task automatic test_brightness();
      logic [CSR_DATA_W-1:0] levels[8];
      levels = '{16'd0, 16'd1, 16'd128, 16'd255, 16'd256, 16'd257, 16'd511, 16'hFFFF};
      apply_setting(CSR_DATA_W'(FULL_SCALE), 16'h1234, 16'hABCD, 16'h0000);
      foreach (levels[i]) begin
         write_csr(CSR_BRIGHTNESS, levels[i]);
         csr_release();
         send_pixel(make_pixel($urandom_range(0, PIXELS - 1), 255, 8'h80, 8'h7F));
         wait_idle();
      end
   endtask

   // Largest head offset with the last pixel gives the highest slot.
   task automatic test_head_offset();
      apply_setting(CSR_DATA_W'(FULL_SCALE), 16'h00C8, 16'h0037, 16'h00FF);
      send_pixel(make_pixel(PIXELS - 1, 8'hC3, 8'h3C, 8'h99));
      send_pixel(make_pixel(0, 8'h66, 8'h81, 8'h18));
      wait_idle();
   endtask

   // Writes to unmapped indexes must leave every register as it was.
   task automatic test_unknown_register();
      for (int k = int'(CSR_HEAD) + 1; k < (1 << CSR_IDX_W); k++)
         write_csr(CSR_IDX_W'(k), 16'hFFFF);
      csr_release();
      send_pixel(make_pixel(100, 8'hE7, 8'h24, 8'h5A));
      wait_idle();
   endtask

   // Random pixels in phases; each phase gets a fresh register setting and
   // its own pacing. Phases 0 and 1 pin the register extremes.
   task automatic test_random_traffic();
      int total;
      int phase;
      int count;
      logic [CSR_DATA_W-1:0] level;
      total = 0;
      phase = 0;
      while (total < RANDOM_ITEMS) begin
         if (phase == 0) begin
            apply_setting(CSR_DATA_W'(FULL_SCALE), 16'hFFFF, 16'h0000, 16'h00FF);
         end else if (phase == 1) begin
            apply_setting(16'h0000, 16'h0000, 16'hFFFF, 16'h0000);
         end else begin
            case ($urandom_range(0, 3))
               0:       level = CSR_DATA_W'($urandom_range(0, FULL_SCALE));
               1:       level = CSR_DATA_W'($urandom);
               2:       level = CSR_DATA_W'(FULL_SCALE);
               default: level = CSR_DATA_W'($urandom_range(1, 255));
            endcase
            apply_setting(level, CSR_DATA_W'($urandom), CSR_DATA_W'($urandom),
                          CSR_DATA_W'($urandom));
         end
         no_gaps = (phase == 1) || ($urandom_range(0, 3) == 0);
         count   = $urandom_range(30, 60);
         if (count > RANDOM_ITEMS - total)
            count = RANDOM_ITEMS - total;
         for (int k = 0; k < count; k++) begin
            send_pixel(random_pixel());
            // sender holds off mid-phase until everything owed has arrived
            if (phase == 2 && k == count / 2)
               wait_idle();
         end
         total += count;
         wait_idle();
         phase++;
      end
      no_gaps = 1'b0;
   endtask

   // ---------------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------------
   initial begin
      errors       = 0;
      pixels_sent  = 0;
      bits_checked = 0;
      csr_writes   = 0;
      cycles       = 0;
      no_gaps      = 1'b0;
      model_csr.brightness_level = LEVEL_W'(FULL_SCALE);
      model_csr.one_high_count   = '0;
      model_csr.zero_high_count  = '0;
      model_csr.head_offset      = '0;
      reset     <= 1'b1;
      start     <= 1'b0;
      req_data  <= '0;
      csr_valid <= 1'b0;
      csr_index <= '0;
      csr_data  <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_field_extremes();
      test_brightness();
      test_head_offset();
      test_unknown_register();
      test_random_traffic();
      wait_idle();

      $display("Run covered %0d pixels, %0d bit transactions, %0d register writes",
               pixels_sent, bits_checked, csr_writes);
      $display("Brightness off to above full, counts and head offset at both ends, %s",
               "indexes past the strip, back-to-back and gapped pixels");
      if (errors == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
